// ===== hdl/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants
// Widths, item layouts, controller states and the command and status groups
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mcr_pkg;

	// sample format and set size
	localparam int SAMPLE_BITS    = 16;
	localparam int MAX_PAIRS_LOG2 = 20;

	// accumulator widths, derived from the sample width and the set size
	localparam int CNT_W = MAX_PAIRS_LOG2 + 1;
	localparam int SUM_W = SAMPLE_BITS + MAX_PAIRS_LOG2 + 1;
	localparam int SQ_W  = 2 * SAMPLE_BITS + MAX_PAIRS_LOG2 - 1;
	localparam int XP_W  = 2 * SAMPLE_BITS + MAX_PAIRS_LOG2;
	localparam int ER_W  = 2 * SAMPLE_BITS + MAX_PAIRS_LOG2 + 1;
	localparam int AB_W  = SAMPLE_BITS + MAX_PAIRS_LOG2 + 1;

	// finalize arithmetic
	localparam int WIDE_W     = 192;  // wide signed temporaries, dividend
	localparam int MB_W       = 96;   // multiplier operand bits, one per cycle
	localparam int R2_SHIFT   = 17;   // 2 * 65536
	localparam int CORR_SHIFT = 32;   // 2^32 scale of squared covariance
	localparam int MAE_SHIFT  = 9;    // 512 = 2 * 256
	localparam int ROOT_W     = 17;
	localparam int RAD_W      = CORR_SHIFT + 2;
	localparam int SR_W       = ROOT_W + 2;

	// result fields
	localparam int COR_W = 16;
	localparam int R2_W  = 32;
	localparam int MAE_W = 24;

	localparam logic [ROOT_W-1:0] COR_ONE   = ROOT_W'(1) << (COR_W - 1);
	localparam logic [COR_W-1:0]  COR_MAX   = {1'b0, {(COR_W-1){1'b1}}};
	localparam logic [R2_W-1:0]   R2_ONE    = R2_W'(1) << (R2_SHIFT - 1);
	localparam logic [R2_W-1:0]   R2_MIN    = {1'b1, {(R2_W-1){1'b0}}};
	localparam logic [R2_W:0]     R2_LIMIT  = {2'b01, {(R2_W-1){1'b0}}}
		+ (R2_W+1)'(R2_ONE);

	typedef struct packed {
		logic signed [15:0] target_value;
		logic signed [15:0] pred_value;
		logic               pair_usable;
		logic               last_of_set;
	} in_item_t;

	typedef struct packed {
		logic signed [COR_W-1:0] correlation;
		logic                    correlation_valid;
		logic signed [R2_W-1:0]  r_squared;
		logic                    r_squared_valid;
		logic [MAE_W-1:0]        mean_abs_error;
		logic                    mae_valid;
		logic [20:0]             pairs_counted;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_LOAD
	} ctrl_state_t;

	// multiply steps, in the order they run
	typedef enum logic [3:0] {
		M_TY1,   // n * Syy
		M_TY2,   // Sy * Sy, subtracted
		M_TP1,   // n * Spp
		M_TP2,   // Sp * Sp, subtracted
		M_C1,    // n * Syp
		M_C2,    // Sy * Sp, subtracted
		M_NR,    // n * Sres, scaled, plus Ty
		M_X,     // C * C, scaled
		M_P      // Ty * Tp
	} mul_sel_t;

	typedef enum logic [1:0] {
		D_MAE,
		D_R2,
		D_COR
	} div_sel_t;

	typedef struct packed {
		logic     acc_en;
		logic     clear;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     div_start;
		div_sel_t div_sel;
		logic     sqrt_start;
		logic     load_out;
	} mcr_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic sqrt_done;
		logic n_ge2;
		logic ty_pos;
		logic tp_pos;
		logic out_full;
	} mcr_sts_t;

endpackage

// ===== hdl/mcr_stream_if.sv =====
// ----------------------------------------------------------------------------
// mcr_stream_if: valid/ready item channel
// One item moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface mcr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/mcr_mul.sv =====
// ----------------------------------------------------------------------------
// mcr_mul: serial shift-add multiplier
// Unsigned product of a wide operand and an MB_W-bit operand, one bit of the
// second operand per cycle.
// ----------------------------------------------------------------------------
module mcr_mul
	import mcr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] a,
	input  logic [MB_W-1:0]   b,
	output logic [WIDE_W-1:0] prod,
	output logic              busy,
	output logic              done
);
	localparam int CW = $clog2(MB_W);

	logic [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0] a_q;
	logic [MB_W-1:0]   b_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MB_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign prod = acc_q;
	assign busy = busy_q;
	assign done = done_q;
endmodule

// ===== hdl/mcr_div.sv =====
// ----------------------------------------------------------------------------
// mcr_div: serial restoring divider
// Unsigned quotient of two WIDE_W-bit values, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcr_div
	import mcr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] dividend,
	input  logic [WIDE_W-1:0] divisor,
	output logic [WIDE_W-1:0] quot,
	output logic              busy,
	output logic              done
);
	localparam int CW = $clog2(WIDE_W);

	logic [WIDE_W-1:0] q_q;
	logic [WIDE_W:0]   r_q;
	logic [WIDE_W-1:0] d_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WIDE_W:0]   r_sh;
	logic              fits;

	assign r_sh = {r_q[WIDE_W-1:0], q_q[WIDE_W-1]};
	assign fits = (r_sh >= {1'b0, d_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift, compare, subtract; dividend register fills with quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= fits ? (r_sh - {1'b0, d_q}) : r_sh;
			q_q <= {q_q[WIDE_W-2:0], fits};
		end
	end

	assign quot = q_q;
	assign busy = busy_q;
	assign done = done_q;
endmodule

// ===== hdl/mcr_datapath.sv =====
// ----------------------------------------------------------------------------
// mcr_datapath: accumulators and finalize arithmetic
// Exact sums per set, the wide variance and covariance terms, the shared
// multiplier and divider, an integer square root and the result register.
// ----------------------------------------------------------------------------
module mcr_datapath
	import mcr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mcr_cmd_t  cmd,
	output mcr_sts_t  sts,
	input  in_item_t  item,
	output out_item_t res_data,
	output logic      res_valid,
	input  logic      res_ready
);
	localparam int S = SAMPLE_BITS;

	// accumulators
	logic [CNT_W-1:0]        n_q;
	logic signed [SUM_W-1:0] sy_q;
	logic signed [SUM_W-1:0] sp_q;
	logic [SQ_W-1:0]         syy_q;
	logic [SQ_W-1:0]         spp_q;
	logic signed [XP_W-1:0]  sxp_q;
	logic [ER_W-1:0]         ser_q;
	logic [AB_W-1:0]         sab_q;

	// per-item terms
	logic signed [S-1:0]   y, p;
	logic signed [S:0]     e;
	logic [S:0]            ae;
	logic signed [2*S-1:0] yy, pp, yp;
	logic signed [2*S+1:0] ee;
	logic                  count_ok;

	assign y  = item.target_value[S-1:0];
	assign p  = item.pred_value[S-1:0];
	assign e  = {y[S-1], y} - {p[S-1], p};
	assign ae = e[S] ? (S+1)'(-e) : (S+1)'(e);
	assign yy = y * y;
	assign pp = p * p;
	assign yp = y * p;
	assign ee = e * e;
	assign count_ok = item.pair_usable && !n_q[CNT_W-1];

	// accumulate one usable pair per accepted item while the count is below 2^20; clear after the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			sy_q  <= '0;
			sp_q  <= '0;
			syy_q <= '0;
			spp_q <= '0;
			sxp_q <= '0;
			ser_q <= '0;
			sab_q <= '0;
		end else if (cmd.clear) begin
			n_q   <= '0;
			sy_q  <= '0;
			sp_q  <= '0;
			syy_q <= '0;
			spp_q <= '0;
			sxp_q <= '0;
			ser_q <= '0;
			sab_q <= '0;
		end else if (cmd.acc_en && count_ok) begin
			n_q   <= n_q + CNT_W'(1);
			sy_q  <= sy_q + {{(SUM_W-S){y[S-1]}}, y};
			sp_q  <= sp_q + {{(SUM_W-S){p[S-1]}}, p};
			syy_q <= syy_q + {{(SQ_W-2*S+1){1'b0}}, yy[2*S-2:0]};
			spp_q <= spp_q + {{(SQ_W-2*S+1){1'b0}}, pp[2*S-2:0]};
			sxp_q <= sxp_q + {{(XP_W-2*S){yp[2*S-1]}}, yp};
			ser_q <= ser_q + {{(ER_W-2*S){1'b0}}, ee[2*S-1:0]};
			sab_q <= sab_q + {{(AB_W-S-1){1'b0}}, ae};
		end
	end

	// wide terms
	logic signed [WIDE_W-1:0] ty_q, tp_q, c_q, num_q, x_q, p_q;

	// magnitudes at full width
	logic [WIDE_W-1:0] n_m, sy_m, sp_m, syy_m, spp_m, sxp_m, ser_m, c_m;
	assign n_m   = {{(WIDE_W-CNT_W){1'b0}}, n_q};
	assign sy_m  = sy_q[SUM_W-1] ? WIDE_W'(-sy_q) : WIDE_W'(sy_q);
	assign sp_m  = sp_q[SUM_W-1] ? WIDE_W'(-sp_q) : WIDE_W'(sp_q);
	assign syy_m = {{(WIDE_W-SQ_W){1'b0}}, syy_q};
	assign spp_m = {{(WIDE_W-SQ_W){1'b0}}, spp_q};
	assign sxp_m = sxp_q[XP_W-1] ? WIDE_W'(-sxp_q) : WIDE_W'(sxp_q);
	assign ser_m = {{(WIDE_W-ER_W){1'b0}}, ser_q};
	assign c_m   = c_q[WIDE_W-1] ? WIDE_W'(-c_q) : WIDE_W'(c_q);

	// multiplier operand select
	logic [WIDE_W-1:0] mul_a, mul_prod;
	logic [MB_W-1:0]   mul_b;
	logic              mul_neg, mul_busy, mul_done;

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		unique case (cmd.mul_sel)
			M_TY1: begin
				mul_a = n_m;
				mul_b = syy_m[MB_W-1:0];
			end
			M_TY2: begin
				mul_a = sy_m;
				mul_b = sy_m[MB_W-1:0];
			end
			M_TP1: begin
				mul_a = n_m;
				mul_b = spp_m[MB_W-1:0];
			end
			M_TP2: begin
				mul_a = sp_m;
				mul_b = sp_m[MB_W-1:0];
			end
			M_C1: begin
				mul_a   = n_m;
				mul_b   = sxp_m[MB_W-1:0];
				mul_neg = sxp_q[XP_W-1];
			end
			M_C2: begin
				mul_a   = sy_m;
				mul_b   = sp_m[MB_W-1:0];
				mul_neg = sy_q[SUM_W-1] ^ sp_q[SUM_W-1];
			end
			M_NR: begin
				mul_a = n_m;
				mul_b = ser_m[MB_W-1:0];
			end
			M_X: begin
				mul_a = c_m;
				mul_b = c_m[MB_W-1:0];
			end
			M_P: begin
				mul_a = ty_q;
				mul_b = tp_q[MB_W-1:0];
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	mcr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.busy   (mul_busy),
		.done   (mul_done)
	);

	logic signed [WIDE_W-1:0] sprod;
	assign sprod = mul_neg ? -$signed(mul_prod) : $signed(mul_prod);

	// multiply writeback
	always_ff @(posedge clk) begin
		if (mul_done) begin
			unique case (cmd.mul_sel)
				M_TY1:   ty_q  <= sprod;
				M_TY2:   ty_q  <= ty_q - sprod;
				M_TP1:   tp_q  <= sprod;
				M_TP2:   tp_q  <= tp_q - sprod;
				M_C1:    c_q   <= sprod;
				M_C2:    c_q   <= c_q - sprod;
				M_NR:    num_q <= (sprod <<< R2_SHIFT) + ty_q;
				M_X:     x_q   <= sprod <<< CORR_SHIFT;
				M_P:     p_q   <= sprod;
				default: p_q   <= p_q;
			endcase
		end
	end

	// divider operand select
	logic [WIDE_W-1:0] div_n, div_d, div_q;
	logic              div_busy, div_done;

	always_comb begin
		div_n = '0;
		div_d = '0;
		unique case (cmd.div_sel)
			D_MAE: begin
				div_n = {{(WIDE_W-AB_W-MAE_SHIFT){1'b0}}, sab_q, {MAE_SHIFT{1'b0}}} + n_m;
				div_d = n_m << 1;
			end
			D_R2: begin
				div_n = num_q;
				div_d = WIDE_W'(ty_q) << 1;
			end
			D_COR: begin
				div_n = x_q;
				div_d = p_q;
			end
			default: begin
				div_n = '0;
			end
		endcase
	end

	mcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.quot     (div_q),
		.busy     (div_busy),
		.done     (div_done)
	);

	// divide writeback, with saturation
	logic [MAE_W-1:0] mae_q;
	logic [R2_W-1:0]  r2_q;
	logic [RAD_W-1:0] rad_q;
	logic             r2_big, d_big;

	assign r2_big = (|div_q[WIDE_W-1:R2_W+1]) || (div_q[R2_W:0] > R2_LIMIT);
	assign d_big  = |div_q[WIDE_W-1:CORR_SHIFT+1];

	// square root iteration, two radicand bits a step
	logic [SR_W-1:0]   rem_q, rem_sh, trial;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        sq_cnt_q;
	logic              sq_busy_q, sq_done_q, sq_fit;

	assign rem_sh = {rem_q[SR_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign sq_fit = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (div_done) begin
			unique case (cmd.div_sel)
				D_MAE:   mae_q <= (|div_q[WIDE_W-1:MAE_W]) ? '1 : div_q[MAE_W-1:0];
				D_R2:    r2_q  <= r2_big ? R2_MIN : (R2_ONE - div_q[R2_W-1:0]);
				D_COR:   rad_q <= d_big
					? {{(RAD_W-CORR_SHIFT-1){1'b0}}, 1'b1, {CORR_SHIFT{1'b0}}}
					: {1'b0, div_q[CORR_SHIFT:0]};
				default: mae_q <= mae_q;
			endcase
		end else if (cmd.sqrt_start) begin
			rem_q  <= '0;
			root_q <= '0;
		end else if (sq_busy_q) begin
			rem_q  <= sq_fit ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], sq_fit};
			rad_q  <= rad_q << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_done_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else begin
			sq_done_q <= 1'b0;
			if (cmd.sqrt_start) begin
				sq_busy_q <= 1'b1;
				sq_cnt_q  <= 5'(ROOT_W - 1);
			end else if (sq_busy_q) begin
				sq_cnt_q <= sq_cnt_q - 5'd1;
				if (sq_cnt_q == '0) begin
					sq_busy_q <= 1'b0;
					sq_done_q <= 1'b1;
				end
			end
		end
	end

	// correlation: round half away from zero from the root, then sign
	logic [ROOT_W-1:0] m_w, m_cap;
	logic [COR_W-1:0]  corr_w;
	assign m_w   = ROOT_W'(({1'b0, root_q} + (ROOT_W+1)'(1)) >> 1);
	assign m_cap = (m_w > COR_ONE) ? COR_ONE : m_w;
	assign corr_w = c_q[WIDE_W-1] ? COR_W'(-m_cap[COR_W-1:0])
		: (m_cap >= COR_ONE ? COR_MAX : m_cap[COR_W-1:0]);

	// status
	logic n_ge2, ty_pos, tp_pos, res_valid_q;
	assign n_ge2  = (n_q >= CNT_W'(2));
	assign ty_pos = !ty_q[WIDE_W-1] && (ty_q != '0);
	assign tp_pos = !tp_q[WIDE_W-1] && (tp_q != '0);

	always_comb begin
		sts.mul_done  = mul_done;
		sts.div_done  = div_done;
		sts.sqrt_done = sq_done_q;
		sts.n_ge2     = n_ge2;
		sts.ty_pos    = ty_pos;
		sts.tp_pos    = tp_pos;
		sts.out_full  = res_valid_q;
	end

	// result register
	out_item_t res_q;
	logic      rv_w, cv_w;
	assign rv_w = n_ge2 && ty_pos;
	assign cv_w = rv_w && tp_pos;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.correlation       <= cv_w ? corr_w : '0;
			res_q.correlation_valid <= cv_w;
			res_q.r_squared         <= rv_w ? r2_q : '0;
			res_q.r_squared_valid   <= rv_w;
			res_q.mean_abs_error    <= n_ge2 ? mae_q : '0;
			res_q.mae_valid         <= n_ge2;
			res_q.pairs_counted     <= n_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_data  = res_q;
	assign res_valid = res_valid_q;

	// checks
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !mul_busy)
		else $error("multiply started while busy");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divide started while busy");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !res_valid_q)
		else $error("result loaded over an untaken result");
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (n_q == '0))
		else $error("pair count not cleared after result");
endmodule

// ===== hdl/mcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcr_ctrl: set controller
// Takes items while accumulating; on the last item of a set it runs the
// multiply, divide and square-root steps needed, then loads the result.
// ----------------------------------------------------------------------------
module mcr_ctrl
	import mcr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	input  mcr_sts_t sts,
	output mcr_cmd_t cmd
);
	ctrl_state_t state_q, state_d;
	mul_sel_t    mstep_q, mstep_d;
	div_sel_t    dstep_q, dstep_d;
	logic        skip_div;

	function automatic mul_sel_t next_mul(input mul_sel_t s);
		mul_sel_t r;
		unique case (s)
			M_TY1:   r = M_TY2;
			M_TY2:   r = M_TP1;
			M_TP1:   r = M_TP2;
			M_TP2:   r = M_C1;
			M_C1:    r = M_C2;
			M_C2:    r = M_NR;
			M_NR:    r = M_X;
			M_X:     r = M_P;
			default: r = M_P;
		endcase
		return r;
	endfunction

	// R squared and correlation both need target variance; correlation
	// also needs prediction variance
	assign skip_div = ((dstep_q == D_R2) && !sts.ty_pos)
		|| ((dstep_q == D_COR) && !sts.tp_pos);

	// next state
	always_comb begin
		state_d = state_q;
		mstep_d = mstep_q;
		dstep_d = dstep_q;
		unique case (state_q)
			ST_ACC: begin
				if (in_valid && in_last) begin
					state_d = ST_MUL_GO;
					mstep_d = M_TY1;
				end
			end
			ST_MUL_GO: begin
				state_d = sts.n_ge2 ? ST_MUL_WAIT : ST_LOAD;
			end
			ST_MUL_WAIT: begin
				if (sts.mul_done) begin
					if (mstep_q == M_P) begin
						state_d = ST_DIV_GO;
						dstep_d = D_MAE;
					end else begin
						state_d = ST_MUL_GO;
						mstep_d = next_mul(mstep_q);
					end
				end
			end
			ST_DIV_GO: begin
				state_d = skip_div ? ST_LOAD : ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					unique case (dstep_q)
						D_MAE: begin
							state_d = ST_DIV_GO;
							dstep_d = D_R2;
						end
						D_R2: begin
							state_d = ST_DIV_GO;
							dstep_d = D_COR;
						end
						default: state_d = ST_SQRT_GO;
					endcase
				end
			end
			ST_SQRT_GO: begin
				state_d = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: begin
				if (sts.sqrt_done) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!sts.out_full) state_d = ST_ACC;
			end
			default: state_d = ST_ACC;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = (state_q == ST_ACC);
		cmd.acc_en     = (state_q == ST_ACC) && in_valid;
		cmd.mul_sel    = mstep_q;
		cmd.div_sel    = dstep_q;
		cmd.mul_start  = (state_q == ST_MUL_GO) && sts.n_ge2;
		cmd.div_start  = (state_q == ST_DIV_GO) && !skip_div;
		cmd.sqrt_start = (state_q == ST_SQRT_GO);
		cmd.load_out   = (state_q == ST_LOAD) && !sts.out_full;
		cmd.clear      = cmd.load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			mstep_q <= M_TY1;
			dstep_q <= D_MAE;
		end else begin
			state_q <= state_d;
			mstep_q <= mstep_d;
			dstep_q <= dstep_d;
		end
	end
endmodule

// ===== hdl/masked_correlation_r2_mae.sv =====
// ----------------------------------------------------------------------------
// masked_correlation_r2_mae: per-set correlation, R squared and MAE
// Top level: controller, datapath and the two item channels.
// ----------------------------------------------------------------------------
// Samples are taken one item per cycle while a set accumulates; pairs whose
// usable flag is low are passed over but still close the set when marked
// last. After the last item the input is held off while the finalize runs
// on one shared serial multiplier, one serial divider and a 17-step square
// root; the finalize runs fewer steps when the set has under two pairs or a
// variance is zero. A result waits in its output register while the next
// set is already accepted.
module masked_correlation_r2_mae
	import mcr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mcr_stream_if.sink   samples,
	mcr_stream_if.source results
);
	mcr_cmd_t  cmd;
	mcr_sts_t  sts;
	in_item_t  item;
	out_item_t res;

	assign item = samples.data;

	mcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_last  (item.last_of_set),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.res_data  (res),
		.res_valid (results.valid),
		.res_ready (results.ready)
	);

	assign results.data = res;
endmodule
